@@ hdl/lruet_pkg.sv @@
`default_nettype none

package lruet_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;
  localparam int SIZE_W   = 32;
  localparam int SUM_W    = 36;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OP_W     = 2;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] MAX_RESET = CNT_W'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_PLACE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [KEY_BITS-1:0] key;
    logic [SIZE_W-1:0]   size;
  } store_wr_t;

endpackage

`default_nettype wire

@@ hdl/lruet_store.sv @@
`default_nettype none

module lruet_store
  import lruet_pkg::*;
(
  input  wire logic                clk,
  input  wire store_wr_t           wr,
  input  wire logic [IDX_W-1:0]    rd_addr,
  output logic      [KEY_BITS-1:0] rd_key,
  output logic      [SIZE_W-1:0]   rd_size
);

  logic [KEY_BITS-1:0] key_mem  [DEPTH];
  logic [SIZE_W-1:0]   size_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr]  <= wr.key;
      size_mem[wr.addr] <= wr.size;
    end
  end

  always_ff @(posedge clk) begin
    rd_key  <= key_mem[rd_addr];
    rd_size <= size_mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/lru_eviction_table.sv @@
// LRU eviction table: up to 16 keys with byte sizes, kept in recency order.
// Input channel (in_valid / in_stall) carries opcode, key and item_size:
// access, insert, remove or evict least recent. Each beat yields exactly one
// result beat on the output channel (out_valid / out_stall) with hit,
// evicted key, overflow, total size, entry count and the eviction advice.
// One comparator walks the slots one per cycle, reading key and size from
// the store; after the scan come an apply step, a place step for an insert
// that writes a slot, and the result step. in_stall is high through these
// steps; the next item is taken once the result sits in the output register.
// If the receiver stalls, the result holds in that register; a following
// item may still run, and waits at its result step until the register frees.
// The advice limit is written via cfg_valid / cfg_ready (always ready), by
// the user only while idle (not enforced by the block), and resets to 16.
// Reset clears the table, totals and pending result but not key/size storage.
`default_nettype none

module lru_eviction_table
  import lruet_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [SIZE_W-1:0]   item_size,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     hit,
  output logic                     evicted_valid,
  output logic      [KEY_BITS-1:0] evicted_key,
  output logic                     overflow,
  output logic      [SUM_W-1:0]    total_size,
  output logic      [CNT_W-1:0]    num_entries,
  output logic                     evict_advised,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CNT_W-1:0]    cfg_data
);

  state_t state, state_next;

  logic [CNT_W-1:0]    advise_limit;
  logic [DEPTH-1:0]    valid;
  logic [IDX_W-1:0]    rank [DEPTH];
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;

  op_t                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SIZE_W-1:0]   size_q;
  logic [IDX_W-1:0]    idx;

  logic                found;
  logic [IDX_W-1:0]    tslot;
  logic [IDX_W-1:0]    trank;
  logic [KEY_BITS-1:0] tkey;
  logic [SIZE_W-1:0]   tsize;
  logic                free_found;
  logic [IDX_W-1:0]    fslot;
  logic                ovf_q;

  logic [IDX_W-1:0]    rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [SIZE_W-1:0]   rd_size;
  store_wr_t           wr;
  logic                match;
  logic                out_load;
  logic                drop;
  logic [IDX_W-1:0]    pslot;

  lruet_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_size (rd_size)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      advise_limit <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      advise_limit <= cfg_data;
    end
  end

  // Shared comparator: key equality, or least-recent rank for evict
  always_comb begin
    if (op_q == OP_EVICT) begin
      match = valid[idx] && (CNT_W'(rank[idx]) == CNT_W'(count - 1'b1));
    end else begin
      match = valid[idx] && (rd_key == key_q);
    end
  end

  assign drop  = found && (op_q != OP_ACCESS);
  assign pslot = found ? tslot : fslot;

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    rd_addr    = '0;
    wr.en      = 1'b0;
    wr.addr    = pslot;
    wr.key     = key_q;
    wr.size    = size_q;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = IDX_W'(idx + 1'b1);
        if (idx == IDX_LAST) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (op_q == OP_INSERT && (found || free_found)) begin
          state_next = ST_PLACE;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_PLACE: begin
        wr.en      = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture and slot scan
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      ovf_q      <= 1'b0;
      idx        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q       <= op_t'(opcode);
            key_q      <= key;
            size_q     <= item_size;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            ovf_q      <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (match && !found) begin
            found <= 1'b1;
            tslot <= idx;
            trank <= rank[idx];
            tkey  <= rd_key;
            tsize <= rd_size;
          end
          if (!valid[idx] && !free_found) begin
            free_found <= 1'b1;
            fslot      <= idx;
          end
          idx <= IDX_W'(idx + 1'b1);
        end
        ST_APPLY: begin
          ovf_q <= (op_q == OP_INSERT) && !found && !free_found;
        end
        ST_PLACE, ST_RESULT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Recency ranks, valid bits and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      sum   <= '0;
      count <= '0;
      for (int j = 0; j < DEPTH; j++) begin
        rank[j] <= '0;
      end
    end else if (state == ST_APPLY) begin
      if (found && op_q == OP_ACCESS) begin
        for (int j = 0; j < DEPTH; j++) begin
          if (valid[j] && rank[j] < trank) begin
            rank[j] <= IDX_W'(rank[j] + 1'b1);
          end
        end
        rank[tslot] <= '0;
      end else if (drop) begin
        for (int j = 0; j < DEPTH; j++) begin
          if (valid[j] && rank[j] > trank) begin
            rank[j] <= IDX_W'(rank[j] - 1'b1);
          end
        end
        valid[tslot] <= 1'b0;
        sum          <= SUM_W'(sum - SUM_W'(tsize));
        count        <= CNT_W'(count - 1'b1);
      end
    end else if (state == ST_PLACE) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (valid[j]) begin
          rank[j] <= IDX_W'(rank[j] + 1'b1);
        end
      end
      rank[pslot]  <= '0;
      valid[pslot] <= 1'b1;
      sum          <= SUM_W'(sum + SUM_W'(size_q));
      count        <= CNT_W'(count + 1'b1);
    end
  end

  // Output register: hold until the receiver takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit           <= found && (op_q != OP_EVICT);
      evicted_valid <= found && (op_q == OP_EVICT);
      evicted_key   <= (found && op_q == OP_EVICT) ? tkey : '0;
      overflow      <= ovf_q;
      total_size    <= sum;
      num_entries   <= count;
      evict_advised <= count >= advise_limit;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count disagrees with valid bits");

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_PLACE |-> count < CNT_W'(DEPTH))
    else $error("slot write into a full table");

  a_evict_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> !hit && !overflow)
    else $error("evict result also flags hit or overflow");

endmodule

`default_nettype wire
